### src/tpag_pkg.sv
// Shared types and constants for the tensor permute address generator.
`default_nettype none

package tpag_pkg;

  localparam int unsigned RANK_W     = 3;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned INDEX_W    = 32;
  localparam int unsigned SHAPE_W    = 32;
  localparam int unsigned PERM_W     = 8;
  // wide enough to hold any rank and any dimension count up to eight
  localparam int unsigned CNT_W      = 4;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANK     = 2'd1,
    STATUS_AXIS     = 2'd2,
    STATUS_DUP_AXIS = 2'd3
  } status_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TENSOR_RANK = 3'd0,
    REG_PERM_RANK   = 3'd1,
    REG_SHAPE       = 3'd2,
    REG_PERM        = 3'd3,
    REG_TRANSPOSE   = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_STRIDE,
    PH_DELTA
  } phase_e;

  typedef struct packed {
    logic               busy;
    status_e            status;
    logic [RANK_W-1:0]  rank;
  } plan_ctrl_t;

  typedef struct packed {
    logic [INDEX_W-1:0] dest_index;
    logic [VALUE_W-1:0] out_value;
    status_e            status;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

### src/tpag_if.sv
// Handshake interfaces: element input, result output and configuration write.
`default_nettype none

interface tpag_in_if;
  logic                          valid;
  logic                          ready;
  logic [tpag_pkg::VALUE_W-1:0]  in_value;

  modport source (output valid, output in_value, input ready);
  modport sink   (input valid, input in_value, output ready);
endinterface

interface tpag_out_if;
  logic                          valid;
  logic                          ready;
  logic [tpag_pkg::INDEX_W-1:0]  dest_index;
  logic [tpag_pkg::VALUE_W-1:0]  out_value;
  tpag_pkg::status_e             status;
  logic                          last;

  modport source (output valid, output dest_index, output out_value, output status,
                  output last, input ready);
  modport sink   (input valid, input dest_index, input out_value, input status,
                  input last, output ready);
endinterface

interface tpag_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tpag_pkg::REG_IDX_W-1:0]   index;
  logic [tpag_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/tpag_plan.sv
// Configuration registers, permutation check and stride/step-delta sequencer.
`default_nettype none

module tpag_plan #(
  parameter int unsigned MAX_DIMS    = 4,
  parameter int unsigned EXTENT_BITS = 8
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  tpag_cfg_if.sink                                         cfg_i,
  output tpag_pkg::plan_ctrl_t                             ctrl_o,
  output logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]             ext_m1_o,
  output logic [MAX_DIMS-1:0][tpag_pkg::INDEX_W-1:0]       delta_o
);

  import tpag_pkg::*;

  localparam int unsigned AB   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned SHW  = (MAX_DIMS * EXTENT_BITS > SHAPE_W) ?
                                 MAX_DIMS * EXTENT_BITS : SHAPE_W;
  localparam int unsigned PMW  = (MAX_DIMS * AB > PERM_W) ? MAX_DIMS * AB : PERM_W;
  localparam logic [CNT_W-1:0] MAX_DIMS_C = CNT_W'(MAX_DIMS);

  logic [RANK_W-1:0]  tensor_rank_q, tensor_rank_d;
  logic [RANK_W-1:0]  perm_rank_q, perm_rank_d;
  logic [SHAPE_W-1:0] shape_q, shape_d;
  logic [PERM_W-1:0]  perm_q, perm_d;
  logic               transpose_q, transpose_d;

  phase_e             phase_q, phase_d;
  logic [AB-1:0]      idx_q, idx_d;
  logic [INDEX_W-1:0] acc_q, acc_d;

  logic [MAX_DIMS-1:0][INDEX_W-1:0] stride_q, stride_d;
  logic [MAX_DIMS-1:0][INDEX_W-1:0] delta_q, delta_d;

  logic [SHW-1:0]                        shape_ext;
  logic [PMW-1:0]                        perm_ext;
  logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]  ext_a;
  logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]  ext_m1;
  logic [CNT_W-1:0]                      rank4;
  status_e                               status;
  logic                                  cfg_fire;

  assign shape_ext = SHW'(shape_q);
  assign perm_ext  = PMW'(perm_q);
  assign rank4     = CNT_W'(tensor_rank_q);
  assign cfg_i.ready = 1'b1;
  assign cfg_fire  = cfg_i.valid;

  // zero extent counts as one
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      ext_a[d] = shape_ext[d*EXTENT_BITS +: EXTENT_BITS];
      if (ext_a[d] == '0) begin
        ext_a[d] = EXTENT_BITS'(1);
      end
      ext_m1[d] = ext_a[d] - EXTENT_BITS'(1);
    end
  end

  // permutation check: rank first, then output axes from 0 upward (rank only in transpose mode)
  always_comb begin
    logic [MAX_DIMS-1:0] seen;
    logic [AB-1:0]       a;
    seen   = '0;
    a      = '0;
    status = STATUS_OK;
    if (transpose_q) begin
      if (rank4 > MAX_DIMS_C) begin
        status = STATUS_RANK;
      end
    end else if ((tensor_rank_q != perm_rank_q) || (rank4 > MAX_DIMS_C)) begin
      status = STATUS_RANK;
    end else begin
      for (int k = 0; k < MAX_DIMS; k++) begin
        a = perm_ext[k*AB +: AB];
        if ((CNT_W'(k) < rank4) && (status == STATUS_OK)) begin
          if (CNT_W'(a) >= rank4) begin
            status = STATUS_AXIS;
          end else if (seen[a]) begin
            status = STATUS_DUP_AXIS;
          end else begin
            seen[a] = 1'b1;
          end
        end
      end
    end
  end

  // after every write to a mapped register: destination stride of each source axis,
  // then the index step taken when the counter carries into each dimension
  always_comb begin
    logic             wr_hit;
    logic             act;
    logic [CNT_W-1:0] a4;
    tensor_rank_d = tensor_rank_q;
    perm_rank_d   = perm_rank_q;
    shape_d       = shape_q;
    perm_d        = perm_q;
    transpose_d   = transpose_q;
    phase_d       = phase_q;
    idx_d         = idx_q;
    acc_d         = acc_q;
    stride_d      = stride_q;
    delta_d       = delta_q;
    wr_hit        = 1'b1;
    act           = CNT_W'(idx_q) < rank4;
    if (transpose_q) begin
      a4 = rank4 - CNT_W'(1) - CNT_W'(idx_q);
    end else begin
      a4 = CNT_W'(perm_ext[idx_q*AB +: AB]);
    end

    if (cfg_fire) begin
      case (reg_e'(cfg_i.index))
        REG_TENSOR_RANK: tensor_rank_d = cfg_i.data[RANK_W-1:0];
        REG_PERM_RANK:   perm_rank_d   = cfg_i.data[RANK_W-1:0];
        REG_SHAPE:       shape_d       = cfg_i.data[SHAPE_W-1:0];
        REG_PERM:        perm_d        = cfg_i.data[PERM_W-1:0];
        REG_TRANSPOSE:   transpose_d   = cfg_i.data[0];
        default:         wr_hit        = 1'b0;
      endcase
      if (wr_hit) begin
        phase_d = PH_STRIDE;
        idx_d   = AB'(MAX_DIMS - 1);
        acc_d   = INDEX_W'(1);
      end
    end else begin
      case (phase_q)
        PH_STRIDE: begin
          if (act && (a4 < MAX_DIMS_C)) begin
            stride_d[a4[AB-1:0]] = acc_q;
            acc_d = acc_q * INDEX_W'(ext_a[a4[AB-1:0]]);
          end
          if (idx_q == '0) begin
            phase_d = PH_DELTA;
            idx_d   = AB'(MAX_DIMS - 1);
            acc_d   = '0;
          end else begin
            idx_d = idx_q - AB'(1);
          end
        end
        PH_DELTA: begin
          if (act) begin
            delta_d[idx_q] = stride_q[idx_q] - acc_q;
            acc_d = acc_q + stride_q[idx_q] * INDEX_W'(ext_m1[idx_q]);
          end
          if (idx_q == '0) begin
            phase_d = PH_IDLE;
          end else begin
            idx_d = idx_q - AB'(1);
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tensor_rank_q <= '0;
      perm_rank_q   <= '0;
      shape_q       <= '0;
      perm_q        <= '0;
      transpose_q   <= 1'b0;
      phase_q       <= PH_IDLE;
      idx_q         <= '0;
    end else begin
      tensor_rank_q <= tensor_rank_d;
      perm_rank_q   <= perm_rank_d;
      shape_q       <= shape_d;
      perm_q        <= perm_d;
      transpose_q   <= transpose_d;
      phase_q       <= phase_d;
      idx_q         <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    stride_q <= stride_d;
    delta_q  <= delta_d;
  end

  assign ctrl_o.busy   = (phase_q != PH_IDLE);
  assign ctrl_o.status = status;
  assign ctrl_o.rank   = tensor_rank_q;
  assign ext_m1_o      = ext_m1;
  assign delta_o       = delta_q;

endmodule

`default_nettype wire

### src/tpag_walk.sv
// Coordinate counter and running destination index, one element per cycle while fire_i is high.
`default_nettype none

module tpag_walk #(
  parameter int unsigned MAX_DIMS    = 4,
  parameter int unsigned EXTENT_BITS = 8
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        fire_i,
  input  wire logic                                        clear_i,
  input  wire tpag_pkg::plan_ctrl_t                        ctrl_i,
  input  wire logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]        ext_m1_i,
  input  wire logic [MAX_DIMS-1:0][tpag_pkg::INDEX_W-1:0]  delta_i,
  output logic [tpag_pkg::INDEX_W-1:0]                     dest_o,
  output tpag_pkg::status_e                                status_o,
  output logic                                             last_o
);

  import tpag_pkg::*;

  localparam int unsigned AB = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] coord_q, coord_d;
  logic [INDEX_W-1:0]                   dest_q, dest_d;

  logic [CNT_W-1:0] rank4;
  logic             ok;
  logic             advance;
  logic             found;
  logic [AB-1:0]    carry;
  logic             last_all;

  assign rank4   = CNT_W'(ctrl_i.rank);
  assign ok      = (ctrl_i.status == STATUS_OK);
  assign advance = fire_i && ok && (ctrl_i.rank != '0);

  // carry lands on the highest active dimension not yet at its end
  always_comb begin
    found    = 1'b0;
    carry    = '0;
    last_all = 1'b1;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if ((CNT_W'(d) < rank4) && (coord_q[d] < ext_m1_i[d])) begin
        found    = 1'b1;
        carry    = AB'(d);
        last_all = 1'b0;
      end
    end
  end

  always_comb begin
    coord_d = coord_q;
    dest_d  = dest_q;
    if (clear_i) begin
      coord_d = '0;
      dest_d  = '0;
    end else if (advance) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        if (CNT_W'(d) < rank4) begin
          if (!found || (AB'(d) > carry)) begin
            coord_d[d] = '0;
          end else if (AB'(d) == carry) begin
            coord_d[d] = coord_q[d] + EXTENT_BITS'(1);
          end
        end
      end
      dest_d = found ? (dest_q + delta_i[carry]) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_q <= '0;
      dest_q  <= '0;
    end else begin
      coord_q <= coord_d;
      dest_q  <= dest_d;
    end
  end

  always_comb begin
    status_o = ctrl_i.status;
    if (!ok) begin
      dest_o = '0;
      last_o = 1'b0;
    end else if (ctrl_i.rank == '0) begin
      dest_o = '0;
      last_o = 1'b1;
    end else begin
      dest_o = dest_q;
      last_o = last_all;
    end
  end

endmodule

`default_nettype wire

### src/tpag_out_buf.sv
// Two-entry result buffer so the input side keeps moving while the sink stalls.
`default_nettype none

module tpag_out_buf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tpag_pkg::res_t data_i,
  output logic                space_o,
  tpag_out_if.source          res_o
);

  import tpag_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  res_t       head_q, head_d;
  res_t       spare_q, spare_d;
  logic       pop;

  assign pop     = (cnt_q != 2'd0) && res_o.ready;
  assign space_o = (cnt_q != 2'd2);

  always_comb begin
    cnt_d   = cnt_q;
    head_d  = head_q;
    spare_d = spare_q;
    case (cnt_q)
      2'd0: begin
        if (push_i) begin
          head_d = data_i;
          cnt_d  = 2'd1;
        end
      end
      2'd1: begin
        if (push_i && pop) begin
          head_d = data_i;
        end else if (push_i) begin
          spare_d = data_i;
          cnt_d   = 2'd2;
        end else if (pop) begin
          cnt_d = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_d = spare_q;
          cnt_d  = 2'd1;
        end
      end
      default: cnt_d = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    spare_q <= spare_d;
  end

  assign res_o.valid      = (cnt_q != 2'd0);
  assign res_o.dest_index = head_q.dest_index;
  assign res_o.out_value  = head_q.out_value;
  assign res_o.status     = head_q.status;
  assign res_o.last       = head_q.last;

endmodule

`default_nettype wire

### src/tensor_permute_address_gen_core.sv
// Tensor axis permutation address generator: top level.
//
// Elements enter on in_i in row-major order of the input tensor, one per
// transfer. For each element one result leaves on res_o: the flat index of
// the element in the permuted tensor, the value unchanged, the status of the
// permutation and a flag on the final element. Registers are written on cfg_i
// (index 0 tensor rank, 1 permutation rank, 2 packed shape, 3 packed axis
// list, 4 transpose mode); cfg_i is always ready.
// Throughput is one element per cycle while in_i is ready; a result is in the
// output buffer in the cycle after its input transfer. The two-entry output
// buffer keeps in_i ready for up to two results while res_o stalls, then in_i
// holds ready low. Every write to a mapped register clears the coordinate
// counter and starts a sequencer that walks the dimensions twice (strides, then
// carry steps); in_i is not ready while the sequencer runs or a write is
// offered. A write to an unmapped index changes nothing.
// Reset clears the configuration registers and the counter; rank zero with
// status OK passes each element at index 0 with the last flag set.
`default_nettype none

module tensor_permute_address_gen_core #(
  parameter int unsigned MAX_DIMS    = 4,
  parameter int unsigned EXTENT_BITS = 8,
  parameter int unsigned DATA_BITS   = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tpag_in_if.sink     in_i,
  tpag_out_if.source  res_o,
  tpag_cfg_if.sink    cfg_i
);

  import tpag_pkg::*;

  localparam logic [VALUE_W-1:0] VAL_MASK = (DATA_BITS >= VALUE_W) ? '1 :
                                            VALUE_W'((64'd1 << DATA_BITS) - 64'd1);

  plan_ctrl_t                            ctrl;
  logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]  ext_m1;
  logic [MAX_DIMS-1:0][INDEX_W-1:0]      delta;
  logic [INDEX_W-1:0]                    dest;
  status_e                               status;
  logic                                  last;
  logic                                  space;
  logic                                  fire;
  logic                                  cfg_hit;
  res_t                                  res;

  assign in_i.ready = space && !ctrl.busy && !cfg_i.valid;
  assign fire       = in_i.valid && in_i.ready;
  // only a write to a mapped register restarts the counter
  assign cfg_hit    = cfg_i.valid && (cfg_i.index <= REG_TRANSPOSE);

  tpag_plan #(
    .MAX_DIMS    (MAX_DIMS),
    .EXTENT_BITS (EXTENT_BITS)
  ) u_plan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .ctrl_o   (ctrl),
    .ext_m1_o (ext_m1),
    .delta_o  (delta)
  );

  tpag_walk #(
    .MAX_DIMS    (MAX_DIMS),
    .EXTENT_BITS (EXTENT_BITS)
  ) u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .clear_i  (cfg_hit),
    .ctrl_i   (ctrl),
    .ext_m1_i (ext_m1),
    .delta_i  (delta),
    .dest_o   (dest),
    .status_o (status),
    .last_o   (last)
  );

  assign res.dest_index = dest;
  assign res.out_value  = in_i.in_value & VAL_MASK;
  assign res.status     = status;
  assign res.last       = last;

  tpag_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .data_i  (res),
    .space_o (space),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire

### test/tensor_permute_address_gen_core_tb.sv
// Self-checking testbench for the tensor permute address generator core.
`default_nettype none

module tensor_permute_address_gen_core_tb;
  import tpag_pkg::*;

  localparam int unsigned MAX_DIMS       = 4;
  localparam int unsigned EXTENT_BITS    = 8;
  localparam int unsigned CLK_PERIOD     = 8;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned SETTLE_CYCLES  = 2 * MAX_DIMS + 2;
  localparam int unsigned RANDOM_ITEMS   = 1500;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned BUSY_PCT       = 81;
  localparam int unsigned LIGHT_PCT      = 15;
  localparam int unsigned REG_COUNT      = 5;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd5;
  localparam int unsigned REG_INDEX_MAX  = (1 << REG_IDX_W) - 1;
  localparam int unsigned DIRECTED_ROWS  = 46;

  typedef enum bit {ROW_WRITE, ROW_ELEMENT} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [REG_IDX_W-1:0]  reg_index;
    logic [31:0]           word;
    bit                    typed;
    res_t                  golden;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;

  tpag_in_if  in_if ();
  tpag_out_if res_if ();
  tpag_cfg_if cfg_if ();

  tensor_permute_address_gen_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // register and counter image of the block
  logic [RANK_W-1:0]      rank_reg;
  logic [RANK_W-1:0]      perm_rank_reg;
  logic [SHAPE_W-1:0]     shape_reg;
  logic [PERM_W-1:0]      axis_list_reg;
  logic                   transpose_reg;
  logic [EXTENT_BITS-1:0] coord [MAX_DIMS];

  res_t        pending_results [$];
  int unsigned failures;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_ELEMENT, '0, 32'hFFFF_FFFF, 1'b1, '{32'd0, 32'hFFFF_FFFF, STATUS_OK, 1'b1}},
    '{ROW_ELEMENT, '0, 32'h0000_0000, 1'b1, '{32'd0, 32'h0000_0000, STATUS_OK, 1'b1}},
    '{ROW_WRITE, REG_TENSOR_RANK, 32'd2, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'hA5A5_A5A5, 1'b1, '{32'd0, 32'hA5A5_A5A5, STATUS_RANK, 1'b0}},
    '{ROW_WRITE, REG_PERM_RANK, 32'd2, 1'b0, '0},
    '{ROW_WRITE, REG_PERM, 32'h0000_0002, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'h5A5A_5A5A, 1'b1, '{32'd0, 32'h5A5A_5A5A, STATUS_AXIS, 1'b0}},
    '{ROW_WRITE, REG_PERM, 32'h0000_0000, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'h0000_0001, 1'b1, '{32'd0, 32'h0000_0001, STATUS_DUP_AXIS, 1'b0}},
    '{ROW_WRITE, REG_PERM, 32'h0000_0001, 1'b0, '0},
    '{ROW_WRITE, REG_SHAPE, 32'h0000_0302, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'h0000_0010, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'h0000_0011, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'h0000_0012, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'h0000_0013, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'h0000_0014, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'h0000_0015, 1'b0, '0},
    // rewrite of the same shape after a full tensor: counter restarts
    '{ROW_WRITE, REG_SHAPE, 32'h0000_0302, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'h8000_0000, 1'b0, '0},
    '{ROW_WRITE, REG_TRANSPOSE, 32'd1, 1'b0, '0},
    '{ROW_WRITE, REG_TENSOR_RANK, 32'd4, 1'b0, '0},
    '{ROW_WRITE, REG_SHAPE, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'hDEAD_BEEF, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'hCAFE_F00D, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'h0F0F_0F0F, 1'b0, '0},
    // zero extents count as one, so every element is the last
    '{ROW_WRITE, REG_SHAPE, 32'h0000_0000, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'h1234_5678, 1'b1, '{32'd0, 32'h1234_5678, STATUS_OK, 1'b1}},
    '{ROW_WRITE, REG_TENSOR_RANK, 32'd7, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'h8765_4321, 1'b1, '{32'd0, 32'h8765_4321, STATUS_RANK, 1'b0}},
    '{ROW_WRITE, REG_TRANSPOSE, 32'd0, 1'b0, '0},
    '{ROW_WRITE, REG_PERM_RANK, 32'd7, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'h7FFF_FFFF, 1'b1, '{32'd0, 32'h7FFF_FFFF, STATUS_RANK, 1'b0}},
    '{ROW_WRITE, REG_TENSOR_RANK, 32'd4, 1'b0, '0},
    '{ROW_WRITE, REG_PERM_RANK, 32'd4, 1'b0, '0},
    '{ROW_WRITE, REG_PERM, 32'h0000_00FF, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'h0000_FFFF, 1'b1, '{32'd0, 32'h0000_FFFF, STATUS_DUP_AXIS, 1'b0}},
    '{ROW_WRITE, REG_PERM, 32'h0000_001B, 1'b0, '0},
    '{ROW_WRITE, REG_SHAPE, 32'hFF01_02FF, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'hFFFF_0000, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'h00FF_00FF, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'hFF00_FF00, 1'b0, '0},
    // unmapped index: no effect, counter keeps going
    '{ROW_WRITE, REG_UNMAPPED, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'h3C3C_3C3C, 1'b0, '0},
    '{ROW_WRITE, REG_TENSOR_RANK, 32'd0, 1'b0, '0},
    '{ROW_WRITE, REG_PERM_RANK, 32'd0, 1'b0, '0},
    '{ROW_ELEMENT, '0, 32'hC3C3_C3C3, 1'b1, '{32'd0, 32'hC3C3_C3C3, STATUS_OK, 1'b1}}
  };

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [31:0] axis_extent(input int d);
    logic [EXTENT_BITS-1:0] e;
    e = shape_reg[EXTENT_BITS*d +: EXTENT_BITS];
    return (e == '0) ? 32'd1 : 32'(e);
  endfunction

  function automatic void apply_register(input logic [REG_IDX_W-1:0] idx,
                                         input logic [31:0] data);
    case (idx)
      REG_TENSOR_RANK: rank_reg = data[RANK_W-1:0];
      REG_PERM_RANK:   perm_rank_reg = data[RANK_W-1:0];
      REG_SHAPE:       shape_reg = data[SHAPE_W-1:0];
      REG_PERM:        axis_list_reg = data[PERM_W-1:0];
      REG_TRANSPOSE:   transpose_reg = data[0];
      default:         return;
    endcase
    for (int d = 0; d < MAX_DIMS; d++) coord[d] = '0;
  endfunction

  // destination index of one element; advances the coordinate counter
  function automatic res_t permute_destination(input logic [31:0] value);
    logic [1:0]  order [MAX_DIMS];
    bit          used [MAX_DIMS];
    int          rank;
    logic [1:0]  src;
    logic [31:0] dest;
    logic [31:0] stride;
    bit          carry;
    res_t        r;
    rank = int'(rank_reg);
    r.out_value = value;
    r.status = STATUS_OK;
    r.dest_index = '0;
    r.last = 1'b0;
    for (int k = 0; k < MAX_DIMS; k++) begin
      used[k] = 1'b0;
      order[k] = '0;
    end
    if (transpose_reg) begin
      if (rank > MAX_DIMS) r.status = STATUS_RANK;
      else for (int k = 0; k < rank; k++) order[k] = 2'(rank - 1 - k);
    end else if (rank_reg != perm_rank_reg || rank > MAX_DIMS) begin
      r.status = STATUS_RANK;
    end else begin
      for (int k = 0; k < rank; k++) begin
        src = axis_list_reg[2*k +: 2];
        if (r.status == STATUS_OK) begin
          if (int'(src) >= rank) r.status = STATUS_AXIS;
          else if (used[src]) r.status = STATUS_DUP_AXIS;
          else begin
            used[src] = 1'b1;
            order[k] = src;
          end
        end
      end
    end
    if (r.status != STATUS_OK) return r;
    r.last = 1'b1;
    if (rank == 0) return r;
    dest = '0;
    stride = 32'd1;
    for (int k = rank - 1; k >= 0; k--) begin
      dest = dest + 32'(coord[order[k]]) * stride;
      stride = stride * axis_extent(order[k]);
    end
    for (int d = 0; d < rank; d++)
      if (32'(coord[d]) < axis_extent(d) - 1) r.last = 1'b0;
    // entries at or past their end wrap and carry into the next one up
    carry = 1'b1;
    for (int d = rank - 1; d >= 0; d--) begin
      if (carry) begin
        if (32'(coord[d]) >= axis_extent(d) - 1) coord[d] = '0;
        else begin
          coord[d] = coord[d] + 1'b1;
          carry = 1'b0;
        end
      end
    end
    r.dest_index = dest;
    return r;
  endfunction

  task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    apply_register(idx, data);
  endtask

  task automatic send_element(input logic [31:0] value, input bit typed, input res_t golden);
    res_t predicted;
    cfg_if.valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.in_value <= value;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predicted = permute_destination(value);
    pending_results.push_back(typed ? golden : predicted);
  endtask

  // sender pauses until every expected result is back and the block has settled
  task automatic wait_quiet();
    in_if.valid  <= 1'b0;
    cfg_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure_random();
    int          kind;
    int          rank;
    int          j;
    logic [1:0]  order [MAX_DIMS];
    logic [1:0]  swap;
    logic [31:0] values [REG_COUNT];
    reg_e        write_order [REG_COUNT];
    reg_e        held;
    logic [RANK_W-1:0] tr;
    logic [RANK_W-1:0] pr;
    logic [PERM_W-1:0] perm;
    logic [SHAPE_W-1:0] shape;
    logic        tp;
    kind = $urandom_range(0, 9);
    rank = $urandom_range(1, MAX_DIMS);
    for (int k = 0; k < MAX_DIMS; k++) order[k] = 2'(k);
    for (int k = rank - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      swap = order[k];
      order[k] = order[j];
      order[j] = swap;
    end
    perm = PERM_W'($urandom);
    for (int k = 0; k < rank; k++) perm[2*k +: 2] = order[k];
    shape = '0;
    for (int k = 0; k < MAX_DIMS; k++)
      shape[EXTENT_BITS*k +: EXTENT_BITS] = EXTENT_BITS'($urandom_range(0, 4));
    tr = RANK_W'(rank);
    pr = RANK_W'(rank);
    tp = (kind == 5);
    case (kind)
      6: begin
        tp = 1'b1;
        pr = RANK_W'($urandom_range(0, REG_INDEX_MAX));
      end
      7: begin
        tr = '0;
        pr = '0;
      end
      8: begin
        tr = RANK_W'($urandom_range(0, REG_INDEX_MAX));
        pr = $urandom_range(0, 1) ? tr : RANK_W'($urandom_range(0, REG_INDEX_MAX));
        perm = PERM_W'($urandom);
        shape = $urandom;
        tp = 1'($urandom_range(0, 1));
      end
      9: begin
        j = $urandom_range(0, rank - 1);
        shape[EXTENT_BITS*j +: EXTENT_BITS] = EXTENT_BITS'($urandom_range(5, 255));
      end
      default: ;
    endcase
    // upper data bits are don't-care and get random content
    values[REG_TENSOR_RANK] = $urandom;
    values[REG_TENSOR_RANK][RANK_W-1:0] = tr;
    values[REG_PERM_RANK] = $urandom;
    values[REG_PERM_RANK][RANK_W-1:0] = pr;
    values[REG_SHAPE] = shape;
    values[REG_PERM] = $urandom;
    values[REG_PERM][PERM_W-1:0] = perm;
    values[REG_TRANSPOSE] = $urandom;
    values[REG_TRANSPOSE][0] = tp;
    write_order = '{REG_TENSOR_RANK, REG_PERM_RANK, REG_SHAPE, REG_PERM, REG_TRANSPOSE};
    for (int k = REG_COUNT - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      held = write_order[k];
      write_order[k] = write_order[j];
      write_order[j] = held;
    end
    for (int k = 0; k < REG_COUNT; k++) begin
      if ($urandom_range(0, 7) == 0)
        write_register(REG_IDX_W'($urandom_range(REG_COUNT, REG_INDEX_MAX)), $urandom);
      write_register(write_order[k], values[write_order[k]]);
    end
  endtask

  // result receiver; a long hold-off is counted down here
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    res_t expected;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: dest_index %0d value %h", res_if.dest_index,
               res_if.out_value);
        failures++;
      end else begin
        expected = pending_results.pop_front();
        if (res_if.dest_index !== expected.dest_index) begin
          $error("dest_index: expected %0d, got %0d", expected.dest_index, res_if.dest_index);
          failures++;
        end
        if (res_if.out_value !== expected.out_value) begin
          $error("out_value: expected %h, got %h", expected.out_value, res_if.out_value);
          failures++;
        end
        if (res_if.status !== expected.status) begin
          $error("status: expected %0d, got %0d", expected.status, res_if.status);
          failures++;
        end
        if (res_if.last !== expected.last) begin
          $error("last: expected %0d, got %0d", expected.last, res_if.last);
          failures++;
        end
      end
    end
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk_i);
    $display("tensor_permute_address_gen_core verification failed");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned segment;
    int unsigned count;
    failures = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rank_reg = '0;
    perm_rank_reg = '0;
    shape_reg = '0;
    axis_list_reg = '0;
    transpose_reg = 1'b0;
    for (int d = 0; d < MAX_DIMS; d++) coord[d] = '0;
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.in_value <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_quiet();
        write_register(directed_rows[i].reg_index, directed_rows[i].word);
      end else begin
        send_element(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].golden);
      end
    end

    sent = 0;
    segment = 0;
    while (sent < RANDOM_ITEMS) begin
      case (segment % 4)
        0: begin send_idle_pct = 0;         recv_stall_pct = 0;         end
        1: begin send_idle_pct = BUSY_PCT;  recv_stall_pct = 0;         end
        2: begin send_idle_pct = 0;         recv_stall_pct = BUSY_PCT;  end
        default: begin send_idle_pct = LIGHT_PCT; recv_stall_pct = LIGHT_PCT; end
      endcase
      wait_quiet();
      configure_random();
      // back-pressure: output held off while the sender keeps offering
      if (segment == 4) begin
        send_idle_pct = 0;
        hold_left = LONG_HOLD;
      end
      count = $urandom_range(10, 90);
      repeat (count) send_element($urandom, 1'b0, '0);
      sent += count;
      segment++;
    end

    wait_quiet();
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      failures++;
    end
    if (failures == 0) begin
      $display("tensor_permute_address_gen_core verification clean");
    end else begin
      $display("tensor_permute_address_gen_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### tensor_permute_address_gen_core.f
src/tpag_pkg.sv
src/tpag_if.sv
src/tpag_plan.sv
src/tpag_walk.sv
src/tpag_out_buf.sv
src/tensor_permute_address_gen_core.sv
test/tensor_permute_address_gen_core_tb.sv
